/* sv/pzs_pkg.sv */
// Shared types, constants and the channel blend function for the per-zone
// RGB smoothing block. No dependencies.
package pzs_pkg;

    localparam int ZONE_COUNT = 256;
    localparam int ADDR_W     = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int COLOR_W    = 8;
    localparam int ZONE_W     = 8;
    localparam int PIXEL_W    = 3 * COLOR_W;

    // blend weight, 0..256
    localparam int WEIGHT_W   = 9;
    localparam int WEIGHT_MAX = 256;
    localparam int BLEND_SH   = 8;

    // config register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 2'd2;

    localparam int RATE_W   = 8;
    localparam int SETTLE_W = 16;
    localparam logic [RATE_W-1:0]   RATE_RESET   = 8'd30;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd200;
    localparam logic                SMOOTH_RESET = 1'b1;

    // interval_ms = (1000000 / rate) / 1000 == 1000 / rate (nested floors)
    localparam int US_PER_S    = 1000000;
    localparam int US_PER_MS   = 1000;
    localparam int INTERVAL_NUM = US_PER_S / US_PER_MS;

    // weight divider: dividend up to 1000 * 256, divisor up to 65536
    localparam int DIVIDEND_W = 18;
    localparam int DIVISOR_W  = SETTLE_W + 1;
    localparam int REM_W      = DIVISOR_W + 1;
    localparam int STEP_W     = $clog2(DIVIDEND_W);

    typedef enum logic [1:0] {
        WT_START,
        WT_DIV_RATE,
        WT_DIV_SETTLE,
        WT_IDLE
    } wt_state_t;

    typedef struct packed {
        logic [ZONE_W-1:0]  zone_index;
        logic [COLOR_W-1:0] red_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] blue_in;
        logic               frame_end;
    } in_req_t;

    typedef struct packed {
        logic [ZONE_W-1:0]  zone_out;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
        logic               frame_last;
    } out_req_t;

    typedef struct packed {
        logic                busy;
        logic                smoothing_on;
        logic [WEIGHT_W-1:0] weight;
    } wgt_status_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] data;
    } store_wr_t;

    localparam int DIFF_W = COLOR_W + 2;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;

    // prev + ((raw - prev) * w) / 256, division truncating toward zero
    function automatic logic [COLOR_W-1:0] blend_channel(
        input logic [COLOR_W-1:0]  prev,
        input logic [COLOR_W-1:0]  raw,
        input logic [WEIGHT_W-1:0] w
    );
        logic signed [DIFF_W-1:0] d;
        logic signed [PROD_W-1:0] dx;
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] q;
        logic signed [PROD_W-1:0] sum;
        d    = $signed({2'b00, raw}) - $signed({2'b00, prev});
        dx   = PROD_W'(d);
        wx   = $signed({{(PROD_W-WEIGHT_W){1'b0}}, w});
        prod = dx * wx;
        if (prod < 0)
        begin
            q = (prod + $signed(PROD_W'((1 << BLEND_SH) - 1))) >>> BLEND_SH;
        end
        else
        begin
            q = prod >>> BLEND_SH;
        end
        sum = q + $signed({{(PROD_W-COLOR_W){1'b0}}, prev});
        return sum[COLOR_W-1:0];
    endfunction

endpackage

/* sv/pzs_weight.sv */
// Config registers and blend weight computation (shared restoring divider).
// Depends on pzs_pkg.
module pzs_weight (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pzs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pzs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pzs_pkg::wgt_status_t             status
);
    import pzs_pkg::*;

    logic [RATE_W-1:0]     rate_reg,   rate_next;
    logic [SETTLE_W-1:0]   settle_reg, settle_next;
    logic                  smooth_reg, smooth_next;
    wt_state_t             state_reg,  state_next;
    logic [REM_W-1:0]      rem_reg,    rem_next;
    logic [DIVIDEND_W-1:0] quo_reg,    quo_next;
    logic [DIVISOR_W-1:0]  div_reg,    div_next;
    logic [STEP_W-1:0]     cnt_reg,    cnt_next;
    logic [WEIGHT_W-1:0]   weight_reg, weight_next;

    logic                  cfg_hit;
    logic [REM_W-1:0]      trial;
    logic                  ge;
    logic [REM_W-1:0]      rem_step;
    logic [DIVIDEND_W-1:0] quo_step;

    assign cfg_hit = cfg_write &&
                     (cfg_index == CFG_RATE || cfg_index == CFG_SETTLE ||
                      cfg_index == CFG_SMOOTH);

    always_comb
    begin
        rate_next   = rate_reg;
        settle_next = settle_reg;
        smooth_next = smooth_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_RATE:   rate_next   = cfg_data[RATE_W-1:0];
                CFG_SETTLE: settle_next = cfg_data[SETTLE_W-1:0];
                CFG_SMOOTH: smooth_next = cfg_data[0];
                default:    ;
            endcase
        end
    end

    // one quotient bit per cycle
    assign trial    = {rem_reg[REM_W-2:0], quo_reg[DIVIDEND_W-1]};
    assign ge       = (trial >= REM_W'(div_reg));
    assign rem_step = ge ? (trial - REM_W'(div_reg)) : trial;
    assign quo_step = {quo_reg[DIVIDEND_W-2:0], ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WT_START:      state_next = WT_DIV_RATE;
            WT_DIV_RATE:   if (cnt_reg == '0) state_next = WT_DIV_SETTLE;
            WT_DIV_SETTLE: if (cnt_reg == '0) state_next = WT_IDLE;
            WT_IDLE:       state_next = WT_IDLE;
            default:       state_next = WT_START;
        endcase
        if (cfg_hit)
        begin
            state_next = WT_START;
        end
    end

    // datapath
    always_comb
    begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        weight_next = weight_reg;
        case (state_reg)
            WT_START:
            begin
                // rate 0 counts as 1 Hz
                rem_next = '0;
                quo_next = DIVIDEND_W'(INTERVAL_NUM);
                div_next = (rate_reg == '0) ? DIVISOR_W'(1) : DIVISOR_W'(rate_reg);
                cnt_next = STEP_W'(DIVIDEND_W - 1);
            end
            WT_DIV_RATE:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // interval_ms * 256 / (settling + 1)
                    rem_next = '0;
                    quo_next = quo_step << BLEND_SH;
                    div_next = DIVISOR_W'(settle_reg) + 1'b1;
                    cnt_next = STEP_W'(DIVIDEND_W - 1);
                end
            end
            WT_DIV_SETTLE:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    weight_next = (quo_step > DIVIDEND_W'(WEIGHT_MAX)) ?
                                  WEIGHT_W'(WEIGHT_MAX) : quo_step[WEIGHT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_RESET;
            settle_reg <= SETTLE_RESET;
            smooth_reg <= SMOOTH_RESET;
            state_reg  <= WT_START;
            cnt_reg    <= '0;
            weight_reg <= '0;
        end
        else
        begin
            rate_reg   <= rate_next;
            settle_reg <= settle_next;
            smooth_reg <= smooth_next;
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign status.busy         = (state_reg != WT_IDLE);
    assign status.smoothing_on = smooth_reg;
    assign status.weight       = weight_reg;

`ifndef SYNTHESIS
    a_weight_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WT_IDLE) |-> (weight_reg <= WEIGHT_W'(WEIGHT_MAX)))
        else $error("blend weight above limit");
`endif

endmodule

/* sv/pzs_store.sv */
// Per-zone smoothed color store: one write port, one registered read port,
// write-to-read forwarding and per-entry valid bits. Depends on pzs_pkg.
module pzs_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pzs_pkg::store_rd_t            rd,
    input  pzs_pkg::store_wr_t            wr,
    output logic [pzs_pkg::PIXEL_W-1:0]   rd_data
);
    import pzs_pkg::*;

    logic [PIXEL_W-1:0]    mem [ZONE_COUNT];
    logic [ZONE_COUNT-1:0] valid_reg;
    logic [PIXEL_W-1:0]    mem_q_reg;
    logic [PIXEL_W-1:0]    fwd_data_reg;
    logic                  fwd_hit_reg;
    logic                  hit_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            mem_q_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_hit_reg   <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                // same-edge write to the same entry wins over the stale array
                fwd_hit_reg   <= wr.en && (wr.addr == rd.addr);
                hit_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    // never-written entries read as the reset color (zero)
    assign rd_data = fwd_hit_reg   ? fwd_data_reg :
                     hit_valid_reg ? mem_q_reg    : '0;

endmodule

/* sv/per_zone_rgb_smoothing_top.sv */
// Top level of the per-zone RGB smoothing block: input pipeline, blend
// datapath and output register. Depends on pzs_pkg, pzs_weight, pzs_store.
//
// One request in, one request out. Each request carries a zone's 8-bit RGB
// color; the block keeps one smoothed color per zone (256 zones, cleared
// to black at reset) and moves it toward the new color by an exponential
// moving average, new = prev + ((raw - prev) * w) / 256, truncating toward
// zero. The weight w = min(256, (1000 / rate) * 256 / (settling + 1)) is
// recomputed by a bit-serial divider after reset and after every write to
// a defined config register; in_stall stays high while it runs. Until the
// first request with frame_end set has gone through, colors are stored and
// returned unchanged. With smoothing_on cleared, colors pass through and
// the store is left untouched. Once the weight is ready, a request is
// accepted every cycle unless a result held by out_stall blocks stage 1:
// the store is read at accept, blended and written back as the request
// leaves stage 1, and a write to the same zone by the request just ahead
// is forwarded to the read. out_valid rises as a request leaves stage 1
// for the output register. An output register lets a new request enter
// while a finished result still waits under out_stall.
module per_zone_rgb_smoothing_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pzs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pzs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  pzs_pkg::in_req_t                 in_req,
    output logic                             out_valid,
    input  logic                             out_stall,
    output pzs_pkg::out_req_t                out_req
);
    import pzs_pkg::*;

    wgt_status_t        wstat;
    store_rd_t          st_rd;
    store_wr_t          st_wr;
    logic [PIXEL_W-1:0] st_data;

    logic               accept;
    logic               s1_adv;

    // stage 1: request waiting on store read data
    logic               s1_valid_reg, s1_valid_next;
    in_req_t            s1_req_reg;

    // set once a frame has completed
    logic               hist_reg, hist_next;

    logic               out_valid_reg, out_valid_next;
    out_req_t           out_req_reg;

    logic               in_range;
    logic               do_store;
    logic [COLOR_W-1:0] red_new, green_new, blue_new;

    pzs_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (wstat)
    );

    pzs_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (st_rd),
        .wr      (st_wr),
        .rd_data (st_data)
    );

    // stage 1 moves on when the output register is empty or being drained
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = wstat.busy || (s1_valid_reg && !s1_adv);
    assign accept   = in_valid && !in_stall;

    assign st_rd.en   = accept;
    assign st_rd.addr = ADDR_W'(in_req.zone_index);

    assign in_range = (int'(s1_req_reg.zone_index) < ZONE_COUNT);
    assign do_store = wstat.smoothing_on && in_range;

    always_comb
    begin
        red_new   = s1_req_reg.red_in;
        green_new = s1_req_reg.green_in;
        blue_new  = s1_req_reg.blue_in;
        if (do_store && hist_reg)
        begin
            red_new   = blend_channel(st_data[3*COLOR_W-1:2*COLOR_W],
                                      s1_req_reg.red_in, wstat.weight);
            green_new = blend_channel(st_data[2*COLOR_W-1:COLOR_W],
                                      s1_req_reg.green_in, wstat.weight);
            blue_new  = blend_channel(st_data[COLOR_W-1:0],
                                      s1_req_reg.blue_in, wstat.weight);
        end
    end

    // write-back happens as the request leaves stage 1
    assign st_wr.en   = s1_adv && do_store;
    assign st_wr.addr = ADDR_W'(s1_req_reg.zone_index);
    assign st_wr.data = {red_new, green_new, blue_new};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        hist_next = hist_reg || (s1_adv && s1_req_reg.frame_end);

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            hist_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            hist_reg      <= hist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= in_req;
        end
        if (s1_adv)
        begin
            out_req_reg.zone_out   <= s1_req_reg.zone_index;
            out_req_reg.red_out    <= red_new;
            out_req_reg.green_out  <= green_new;
            out_req_reg.blue_out   <= blue_new;
            out_req_reg.frame_last <= s1_req_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request did not reach stage 1");

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("stage 1 request lost on its way out");

    a_hist_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hist_reg) |-> $past(s1_adv && s1_req_reg.frame_end))
        else $error("history set without a completed frame");
`endif

endmodule

/* tb/pzs_ema_checker.sv */
// Checker for the per-zone RGB smoothing block: tracks register writes, predicts each
// result from accepted requests and compares it with what leaves the block.
// Depends on pzs_pkg.
`timescale 1ns / 1ps

module pzs_ema_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [pzs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pzs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  pzs_pkg::in_req_t               in_req,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  pzs_pkg::out_req_t              out_req,
    output int                             mismatch_count,
    output int                             outstanding,
    output int                             results_checked
);
    import pzs_pkg::*;

    logic [PIXEL_W-1:0]  zone_color [0:ZONE_COUNT-1];
    logic                history_seen;
    logic [RATE_W-1:0]   rate_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic                smooth_reg;
    out_req_t            awaited_colors [$];
    out_req_t            want_color;
    int                  zi;

    // min(256, (1000000 / hz / 1000) * 256 / (settle + 1)), zero rate taken as 1 Hz
    function automatic int unsigned ema_weight(input logic [RATE_W-1:0] rate,
                                               input logic [SETTLE_W-1:0] settle);
        int unsigned hz;
        int unsigned interval_ms;
        int unsigned w;
        hz = (rate == '0) ? 32'd1 : 32'(rate);
        interval_ms = (32'd1000000 / hz) / 32'd1000;
        w = (interval_ms * 32'd256) / (32'(settle) + 32'd1);
        return (w > 32'd256) ? 32'd256 : w;
    endfunction

    // signed int division truncates toward zero
    function automatic logic [COLOR_W-1:0] ema_channel(input logic [COLOR_W-1:0] prev,
                                                       input logic [COLOR_W-1:0] raw,
                                                       input int unsigned w);
        int p;
        int d;
        int v;
        p = int'(prev);
        d = int'(raw) - p;
        v = p + (d * int'(w)) / 256;
        return v[COLOR_W-1:0];
    endfunction

    task automatic smooth_zone(input in_req_t req);
        out_req_t           want;
        logic [PIXEL_W-1:0] held;
        int unsigned        w;
        want.zone_out   = req.zone_index;
        want.red_out    = req.red_in;
        want.green_out  = req.green_in;
        want.blue_out   = req.blue_in;
        want.frame_last = req.frame_end;
        w = ema_weight(rate_reg, settle_reg);
        if (smooth_reg && int'(req.zone_index) < ZONE_COUNT)
        begin
            held = zone_color[req.zone_index];
            if (history_seen)
            begin
                want.red_out   = ema_channel(held[23:16], req.red_in, w);
                want.green_out = ema_channel(held[15:8], req.green_in, w);
                want.blue_out  = ema_channel(held[7:0], req.blue_in, w);
            end
            zone_color[req.zone_index] = {want.red_out, want.green_out, want.blue_out};
        end
        if (req.frame_end)
        begin
            history_seen = 1'b1;
        end
        awaited_colors.push_back(want);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t result #%0d: %s", $realtime, results_checked, msg);
        mismatch_count++;
    endtask

    initial
    begin
        mismatch_count  = 0;
        results_checked = 0;
        outstanding     = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (zi = 0; zi < ZONE_COUNT; zi++)
            begin
                zone_color[zi] = '0;
            end
            history_seen = 1'b0;
            rate_reg     = RATE_RESET;
            settle_reg   = SETTLE_RESET;
            smooth_reg   = SMOOTH_RESET;
            awaited_colors.delete();
            outstanding  = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_RATE:   rate_reg   = cfg_data[RATE_W-1:0];
                    CFG_SETTLE: settle_reg = cfg_data[SETTLE_W-1:0];
                    CFG_SMOOTH: smooth_reg = cfg_data[0];
                    default:    ;
                endcase
            end
            // results first: a request accepted on this edge cannot be out yet
            if (out_valid && !out_stall)
            begin
                if (awaited_colors.size() == 0)
                begin
                    report_mismatch($sformatf("zone %0d result with nothing pending",
                                              out_req.zone_out));
                end
                else
                begin
                    want_color = awaited_colors.pop_front();
                    if (out_req.zone_out !== want_color.zone_out)
                        report_mismatch($sformatf("zone got %0d want %0d",
                                                  out_req.zone_out, want_color.zone_out));
                    if (out_req.red_out !== want_color.red_out)
                        report_mismatch($sformatf("zone %0d red got %0d want %0d",
                                                  want_color.zone_out, out_req.red_out,
                                                  want_color.red_out));
                    if (out_req.green_out !== want_color.green_out)
                        report_mismatch($sformatf("zone %0d green got %0d want %0d",
                                                  want_color.zone_out, out_req.green_out,
                                                  want_color.green_out));
                    if (out_req.blue_out !== want_color.blue_out)
                        report_mismatch($sformatf("zone %0d blue got %0d want %0d",
                                                  want_color.zone_out, out_req.blue_out,
                                                  want_color.blue_out));
                    if (out_req.frame_last !== want_color.frame_last)
                        report_mismatch($sformatf("zone %0d frame_last got %b want %b",
                                                  want_color.zone_out, out_req.frame_last,
                                                  want_color.frame_last));
                    results_checked++;
                end
            end
            if (in_valid && !in_stall)
            begin
                smooth_zone(in_req);
            end
            outstanding = awaited_colors.size();
        end
    end

endmodule

/* tb/tb_per_zone_rgb_smoothing_top.sv */
// Top-level testbench for per_zone_rgb_smoothing_top: clock, reset, request and
// register stimulus, output back-pressure, watchdog and verdict.
// Depends on pzs_pkg, per_zone_rgb_smoothing_top and pzs_ema_checker.
`timescale 1ns / 1ps

module tb_per_zone_rgb_smoothing_top;
    import pzs_pkg::*;

    localparam int STALL_PCT      = 35;    // idle / stall chance per cycle, percent
    localparam int HOLD_CYCLES    = 80;    // long receiver hold-off, fills the pipe
    localparam int DRAIN_CYCLES   = 8;     // extra wait after the last result is out
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake and no write
    localparam int PHASE_REQUESTS = 200;

    // index 3 has no register behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_req_t               in_req;
    logic                  out_valid;
    logic                  out_stall;
    out_req_t              out_req;

    int mismatches;
    int outstanding;
    int compared;

    // knobs shared between the stimulus and the receiver process
    bit idling_on    = 1'b1;
    bit hold_request = 1'b0;

    int requests_sent = 0;
    int reg_writes    = 0;
    int phases_run    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    per_zone_rgb_smoothing_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_req   (out_req)
    );

    pzs_ema_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_req          (in_req),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_req         (out_req),
        .mismatch_count  (mismatches),
        .outstanding     (outstanding),
        .results_checked (compared)
    );

    // Color values lean on the extremes so large positive and negative
    // deltas (and the truncation toward zero on negative ones) come up often.
    function automatic logic [COLOR_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until accepted. Random idle cycles go in
    // front of it; valid is only ever assigned once per clock edge.
    task automatic send_zone(input logic [ZONE_W-1:0] zone, input logic [COLOR_W-1:0] red,
                             input logic [COLOR_W-1:0] green,
                             input logic [COLOR_W-1:0] blue, input logic last);
        in_req_t req;
        req.zone_index = zone;
        req.red_in     = red;
        req.green_in   = green;
        req.blue_in    = blue;
        req.frame_end  = last;
        if (idling_on)
        begin
            while ($urandom_range(0, 99) < STALL_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    // Stop offering and wait for every predicted result to come out. The first
    // edge lets the checker record a request accepted on the current one.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register writes only go in with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        reg_writes++;
    endtask

    // All three registers; the unused upper data bits carry junk, the block
    // must keep only the register's own width.
    task automatic set_phase(input logic [RATE_W-1:0] rate, input logic [SETTLE_W-1:0] settle,
                             input logic smooth);
        logic [CFG_DATA_W-1:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_RATE, {junk[15:8], rate});
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_SMOOTH, {junk[14:0], smooth});
        phases_run++;
    endtask

    // A frame: consecutive zones from a random base (wrapping), frame_end on
    // the last one. Mostly short, now and then a long one.
    task automatic send_frame(input int zones);
        logic [ZONE_W-1:0] base;
        base = 8'($urandom);
        for (int i = 0; i < zones; i++)
        begin
            send_zone(base + 8'(i), pick_level(), pick_level(), pick_level(), i == zones - 1);
        end
    endtask

    // Mostly well-formed frames, the rest loose requests at random zones with
    // frame_end set now and then.
    task automatic random_phase(input int budget);
        int first;
        first = requests_sent;
        while (requests_sent - first < budget)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(13, 64)
                                                        : $urandom_range(1, 12));
            end
            else
            begin
                send_zone(8'($urandom), pick_level(), pick_level(), pick_level(),
                          $urandom_range(0, 9) == 0);
            end
        end
    endtask

    // Receiver: random stalls, or none while idling is off. A hold-off
    // request makes it refuse results for HOLD_CYCLES in a row.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (idling_on)
            begin
                out_stall <= ($urandom_range(0, 99) < STALL_PCT);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d cycles without progress, %0d results still pending",
                 WATCHDOG_LIMIT, outstanding);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_RATE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_req    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // Before any frame has ended the store just takes the color (snap).
        send_zone(8'd0,   8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_zone(8'd255, 8'h00, 8'h00, 8'h00, 1'b0);
        send_zone(8'd1,   8'hFF, 8'h00, 8'hAA, 1'b0);
        send_zone(8'd0,   8'h55, 8'hAA, 8'h0F, 1'b0);
        send_zone(8'd128, 8'h80, 8'h7F, 8'h01, 1'b1);

        // History valid from here: blend with the reset weight (rate 30, settle
        // 200). Full-scale drops and rises, a zero delta, and back-to-back
        // requests to one zone so the write-to-read forwarding path is used.
        send_zone(8'd0,   8'h00, 8'h00, 8'h00, 1'b0);
        send_zone(8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_zone(8'd1,   8'h00, 8'hFF, 8'h55, 1'b0);
        send_zone(8'd128, 8'h80, 8'h7F, 8'h01, 1'b0);
        idling_on = 1'b0;
        send_zone(8'd0,   8'hFF, 8'h00, 8'hFF, 1'b0);
        send_zone(8'd0,   8'hFF, 8'h00, 8'hFF, 1'b0);
        send_zone(8'd0,   8'hFF, 8'h00, 8'hFF, 1'b1);
        idling_on = 1'b1;

        // write to the unused index: nothing may change
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_zone(8'd1, 8'h10, 8'h20, 8'h30, 1'b0);

        // smoothing off: colors pass, store untouched, frame_end still seen
        set_phase(8'd30, 16'd200, 1'b0);
        send_zone(8'd0,   8'h12, 8'h34, 8'h56, 1'b0);
        send_zone(8'd255, 8'hFF, 8'h00, 8'h80, 1'b1);

        // rate zero counts as 1 Hz; longest settling gives weight 3
        set_phase(8'd0, 16'hFFFF, 1'b1);
        send_zone(8'd0,   8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_zone(8'd255, 8'h00, 8'h00, 8'h00, 1'b0);

        // highest rate with longest settling: weight 0, the store never moves
        set_phase(8'd255, 16'hFFFF, 1'b1);
        send_zone(8'd0, 8'h00, 8'hFF, 8'h00, 1'b0);

        // weight computes to 1024 and is capped at 256: output follows input
        set_phase(8'd240, 16'd0, 1'b1);
        send_zone(8'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_zone(8'd1, 8'h00, 8'h00, 8'h00, 1'b1);

        // --- random part, one phase per register setting ---
        // reset setting again; the receiver holds off early so the block
        // fills and has to stall requests
        set_phase(8'd30, 16'd200, 1'b1);
        hold_request = 1'b1;
        random_phase(PHASE_REQUESTS);

        // 1 Hz, no settling: capped weight
        set_phase(8'd1, 16'd0, 1'b1);
        random_phase(PHASE_REQUESTS);

        // back-to-back stretch: neither side idles
        idling_on = 1'b0;
        set_phase(8'd1, 16'hFFFF, 1'b1);
        random_phase(PHASE_REQUESTS);
        idling_on = 1'b1;

        // mid-weight; the sender stops halfway until every result is out
        set_phase(8'd60, 16'd40, 1'b1);
        random_phase(PHASE_REQUESTS / 2);
        drain();
        random_phase(PHASE_REQUESTS / 2);

        set_phase(8'd240, 16'hFFFF, 1'b1);
        random_phase(PHASE_REQUESTS);

        set_phase(8'd120, 16'd30, 1'b1);
        random_phase(PHASE_REQUESTS);

        set_phase(8'($urandom), 16'($urandom_range(0, 1000)), 1'b1);
        random_phase(PHASE_REQUESTS);

        set_phase(8'($urandom), 16'($urandom), 1'b0);
        random_phase(PHASE_REQUESTS);

        set_phase(8'($urandom), 16'($urandom_range(0, 255)), 1'b1);
        random_phase(PHASE_REQUESTS);

        drain();

        $display("Run covered %0d requests over %0d register settings (%0d writes).",
                 requests_sent, phases_run, reg_writes);
        $display("%0d results compared; %0d mismatching fields.", compared, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
sv/pzs_pkg.sv
sv/pzs_weight.sv
sv/pzs_store.sv
sv/per_zone_rgb_smoothing_top.sv
tb/pzs_ema_checker.sv
tb/tb_per_zone_rgb_smoothing_top.sv
